FILE: sv/pf_pkg.sv
// pf_pkg: constants, codes, types and the cell-split helper for the playfair block
// used by pf_ctrl, pf_dpath, playfair_digraph_cipher and the bench; no dependencies
package pf_pkg;

  localparam int SIDE     = 5;
  localparam int CELLS    = SIDE * SIDE;
  localparam int LETTERS  = 26;
  localparam int LW       = 5;
  localparam int IW       = 3;

  localparam logic [LW-1:0] LETTER_I = 5'd8;
  localparam logic [LW-1:0] LETTER_J = 5'd9;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_KEY   = 3'd1;
  localparam logic [2:0] CMD_FILL  = 3'd2;
  localparam logic [2:0] CMD_ENC   = 3'd3;
  localparam logic [2:0] CMD_DEC   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ABSENT    = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;

  typedef logic [LW-1:0] letter_t;
  typedef logic [IW-1:0] idx_t;

  typedef struct packed {
    idx_t row;
    idx_t col;
  } rc_t;

  typedef struct packed {
    logic       take_in;
    logic       clear;
    logic       place_kw;
    logic       place_walk;
    logic       walk_clr;
    logic       walk_step;
    logic       set_ready;
    logic       sq_read;
    logic       res_zero;
    logic [1:0] res_st;
    logic       res_sq;
    logic       out_load;
  } pf_ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       ready;
    logic       full;
    logic       a_valid;
    logic       kw_present;
    logic       pair_absent;
    logic       walk_end;
    logic       walk_take;
  } pf_stat_t;

  function automatic rc_t split_cell(letter_t p);
    rc_t r;
    r.row = '0;
    for (int i = 1; i < SIDE; i++) begin
      if (p >= LW'(i * SIDE)) r.row = IW'(i);
    end
    r.col = IW'(p - LW'(r.row * LW'(SIDE)));
    return r;
  endfunction

endpackage

FILE: sv/pf_dpath.sv
// pf_dpath: key square memories, letter flags, fill walk and result registers
// depends on pf_pkg; steered by pf_ctrl through pf_ctl_t
module pf_dpath import pf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pf_ctl_t    ctl,
  output pf_stat_t   stat,
  input  logic [2:0] in_cmd,
  input  letter_t    in_letter_a,
  input  letter_t    in_letter_b,
  output letter_t    out_a,
  output letter_t    out_b,
  output logic [1:0] out_status
);

  logic [2:0]         cmd_r;
  letter_t            la_r, lb_r;
  logic [LETTERS-1:0] present_r, present_nxt;
  letter_t            filled_r, filled_nxt;
  logic               ready_r, ready_nxt;
  letter_t            walk_r, walk_nxt;

  letter_t            place_mem [0:LETTERS-1];
  letter_t            sq_mem    [0:CELLS-1];
  letter_t            pa_r, pb_r;
  letter_t            sqa_r, sqb_r;
  letter_t            res_a_r, res_b_r;
  logic [1:0]         res_st_r;
  letter_t            out_a_r, out_b_r;
  logic [1:0]         out_st_r;

  logic [31:0]        present_ext;
  letter_t            kw_letter, place_letter;
  logic               place_en;
  rc_t                ca, cb, na, nb;
  logic               enc;
  letter_t            addr_a, addr_b;

  assign present_ext  = {{(32-LETTERS){1'b0}}, present_r};
  assign kw_letter    = (la_r == LETTER_J) ? LETTER_I : la_r;
  assign place_en     = ctl.place_kw | ctl.place_walk;
  assign place_letter = ctl.place_kw ? kw_letter : walk_r;

  assign stat.cmd         = cmd_r;
  assign stat.ready       = ready_r;
  assign stat.full        = (filled_r == LW'(CELLS));
  assign stat.a_valid     = (la_r < LW'(LETTERS));
  assign stat.kw_present  = present_ext[kw_letter];
  assign stat.pair_absent = !present_ext[la_r] || !present_ext[lb_r];
  assign stat.walk_end    = (filled_r == LW'(CELLS)) || (walk_r == LW'(LETTERS));
  assign stat.walk_take   = (walk_r != LETTER_J) && !present_ext[walk_r];

  always_comb begin
    filled_nxt  = filled_r;
    present_nxt = present_r;
    ready_nxt   = ready_r;
    walk_nxt    = walk_r;
    if (ctl.clear) begin
      filled_nxt  = '0;
      present_nxt = '0;
      ready_nxt   = 1'b0;
    end else if (place_en) begin
      filled_nxt                = filled_r + 1'b1;
      present_nxt[place_letter] = 1'b1;
    end
    if (ctl.set_ready) ready_nxt = 1'b1;
    if (ctl.walk_clr) begin
      walk_nxt = '0;
    end else if (ctl.walk_step) begin
      walk_nxt = walk_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r  <= '0;
      present_r <= '0;
      ready_r   <= 1'b0;
      walk_r    <= '0;
    end else begin
      filled_r  <= filled_nxt;
      present_r <= present_nxt;
      ready_r   <= ready_nxt;
      walk_r    <= walk_nxt;
    end
  end

  // cell position split and playfair shift
  always_comb begin
    ca  = split_cell(pa_r);
    cb  = split_cell(pb_r);
    enc = (cmd_r == CMD_ENC);
    na  = ca;
    nb  = cb;
    if (ca.row == cb.row) begin
      if (enc) begin
        na.col = (ca.col == IW'(SIDE-1)) ? '0 : ca.col + 1'b1;
        nb.col = (cb.col == IW'(SIDE-1)) ? '0 : cb.col + 1'b1;
      end else begin
        na.col = (ca.col == '0) ? IW'(SIDE-1) : ca.col - 1'b1;
        nb.col = (cb.col == '0) ? IW'(SIDE-1) : cb.col - 1'b1;
      end
    end else if (ca.col == cb.col) begin
      if (enc) begin
        na.row = (ca.row == IW'(SIDE-1)) ? '0 : ca.row + 1'b1;
        nb.row = (cb.row == IW'(SIDE-1)) ? '0 : cb.row + 1'b1;
      end else begin
        na.row = (ca.row == '0) ? IW'(SIDE-1) : ca.row - 1'b1;
        nb.row = (cb.row == '0) ? IW'(SIDE-1) : cb.row - 1'b1;
      end
    end else begin
      na.col = cb.col;
      nb.col = ca.col;
    end
    addr_a = LW'(na.row * LW'(SIDE)) + LW'(na.col);
    addr_b = LW'(nb.row * LW'(SIDE)) + LW'(nb.col);
  end

  always_ff @(posedge clk) begin
    if (ctl.take_in) begin
      cmd_r <= in_cmd;
      la_r  <= in_letter_a;
      lb_r  <= in_letter_b;
      pa_r  <= place_mem[in_letter_a];
      pb_r  <= place_mem[in_letter_b];
    end
    if (place_en) begin
      sq_mem[filled_r]        <= place_letter;
      place_mem[place_letter] <= filled_r;
    end
    if (ctl.sq_read) begin
      sqa_r <= sq_mem[addr_a];
      sqb_r <= sq_mem[addr_b];
    end
    if (ctl.res_zero) begin
      res_a_r  <= '0;
      res_b_r  <= '0;
      res_st_r <= ctl.res_st;
    end else if (ctl.res_sq) begin
      res_a_r  <= sqa_r;
      res_b_r  <= sqb_r;
      res_st_r <= ST_OK;
    end
    if (ctl.out_load) begin
      out_a_r  <= res_a_r;
      out_b_r  <= res_b_r;
      out_st_r <= res_st_r;
    end
  end

  assign out_a      = out_a_r;
  assign out_b      = out_b_r;
  assign out_status = out_st_r;

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> filled_r == LW'(CELLS))
    else $error("square ready while not full");

  a_place_room: assert property (@(posedge clk) disable iff (!rst_n)
    place_en |-> filled_r < LW'(CELLS))
    else $error("letter placed into a full square");

endmodule

FILE: sv/pf_ctrl.sv
// pf_ctrl: command sequencer for the playfair block, handshakes on both channels
// depends on pf_pkg; drives pf_dpath through pf_ctl_t
module pf_ctrl import pf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  pf_stat_t stat,
  output pf_ctl_t  ctl
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_LOOK = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    ctl           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.take_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt    = S_OUT;
        ctl.res_zero = 1'b1;
        ctl.res_st   = ST_OK;
        case (stat.cmd)
          CMD_CLEAR: begin
            ctl.clear = 1'b1;
          end
          CMD_KEY: begin
            if (!stat.a_valid) begin
              ctl.res_st = ST_ABSENT;
            end else if (stat.ready || stat.full) begin
              ctl.res_st = ST_NOT_READY;
            end else if (!stat.kw_present) begin
              ctl.place_kw = 1'b1;
            end
          end
          CMD_FILL: begin
            if (stat.ready) begin
              ctl.res_st = ST_NOT_READY;
            end else begin
              ctl.res_zero = 1'b0;
              ctl.walk_clr = 1'b1;
              state_nxt    = S_FILL;
            end
          end
          CMD_ENC, CMD_DEC: begin
            if (!stat.ready) begin
              ctl.res_st = ST_NOT_READY;
            end else if (stat.pair_absent) begin
              ctl.res_st = ST_ABSENT;
            end else begin
              ctl.res_zero = 1'b0;
              ctl.sq_read  = 1'b1;
              state_nxt    = S_LOOK;
            end
          end
          default: begin
          end
        endcase
      end
      S_FILL: begin
        if (stat.walk_end) begin
          ctl.set_ready = 1'b1;
          ctl.res_zero  = 1'b1;
          ctl.res_st    = ST_OK;
          state_nxt     = S_OUT;
        end else begin
          ctl.walk_step  = 1'b1;
          ctl.place_walk = stat.walk_take;
        end
      end
      S_LOOK: begin
        ctl.res_sq = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          ctl.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_EXEC)
    else $error("accepted word not executed");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result shown outside output state");

endmodule

FILE: sv/playfair_digraph_cipher.sv
// playfair_digraph_cipher: 5x5 playfair key square build and digraph encipher/decipher
// sequence: each word is taken in, executed, then loaded into the output register; pairs
// first read the letter positions, then the cells; a finish fill walks the letters, one letter per cycle
// one word at a time: a new word is taken only after the last one is loaded into the output register
// reset: synchronous active low, square empty and not ready; cell storage not cleared
// depends on pf_pkg, pf_ctrl and pf_dpath
module playfair_digraph_cipher import pf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_cmd,
  input  logic [4:0] in_letter_a,
  input  logic [4:0] in_letter_b,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_a,
  output logic [4:0] out_b,
  output logic [1:0] out_status
);

  pf_ctl_t  ctl;
  pf_stat_t stat;

  pf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  pf_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .stat        (stat),
    .in_cmd      (in_cmd),
    .in_letter_a (in_letter_a),
    .in_letter_b (in_letter_b),
    .out_a       (out_a),
    .out_b       (out_b),
    .out_status  (out_status)
  );

endmodule

FILE: bench/playfair_digraph_cipher_tb.sv
// playfair_digraph_cipher_tb: self-checking bench for the playfair key square and pair cipher
// predicts every result word from its own copy of the square, with random gaps on both sides
// depends on pf_pkg and playfair_digraph_cipher
`timescale 1ns / 1ps

module playfair_digraph_cipher_tb;
  import pf_pkg::*;

  localparam logic [2:0] CMD_LAST = 3'd7;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_WORDS = 550;

  typedef struct packed {
    letter_t    a;
    letter_t    b;
    logic [1:0] st;
  } cipher_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_cmd = CMD_CLEAR;
  letter_t    in_letter_a = '0;
  letter_t    in_letter_b = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  letter_t    out_a;
  letter_t    out_b;
  logic [1:0] out_status;

  // own copy of the key square
  letter_t     sq_cell [CELLS];
  letter_t     pos_of [LETTERS];
  bit          present [LETTERS];
  int unsigned n_placed = 0;
  bit          sq_ready = 1'b0;

  cipher_word_t cipher_words_q [$];

  int n_errors = 0;
  int n_words_in = 0;
  int n_words_out = 0;
  int n_squares = 0;
  int n_pairs = 0;
  int idle_cycles = 0;
  int hold_order = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_gap = 0;
  int rx_run = 0;
  bit rx_quiet = 1'b0;
  bit tx_quiet = 1'b0;
  cipher_word_t want_word;
  cipher_word_t got_word;

  playfair_digraph_cipher dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_letter_a (in_letter_a),
    .in_letter_b (in_letter_b),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_a       (out_a),
    .out_b       (out_b),
    .out_status  (out_status)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void place_in_square(letter_t l);
    sq_cell[n_placed] = l;
    pos_of[l] = letter_t'(n_placed);
    present[l] = 1'b1;
    n_placed++;
  endfunction

  function automatic cipher_word_t playfair_predict(logic [2:0] cmd, letter_t a, letter_t b);
    cipher_word_t r;
    int pa, pb, r1, c1, r2, c2, stepv, t;
    letter_t k;
    r = '0;
    r.st = ST_OK;
    case (cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < LETTERS; i++) present[i] = 1'b0;
        n_placed = 0;
        sq_ready = 1'b0;
      end
      CMD_KEY: begin
        if (a >= LETTERS) r.st = ST_ABSENT;
        else if (sq_ready || n_placed >= CELLS) r.st = ST_NOT_READY;
        else begin
          k = (a == LETTER_J) ? LETTER_I : a;
          if (!present[k]) place_in_square(k);
        end
      end
      CMD_FILL: begin
        if (sq_ready) r.st = ST_NOT_READY;
        else begin
          for (int l = 0; l < LETTERS && n_placed < CELLS; l++) begin
            if (letter_t'(l) != LETTER_J && !present[l]) place_in_square(letter_t'(l));
          end
          sq_ready = 1'b1;
        end
      end
      CMD_ENC, CMD_DEC: begin
        if (!sq_ready) r.st = ST_NOT_READY;
        else if (a >= LETTERS || b >= LETTERS || !present[a] || !present[b]) r.st = ST_ABSENT;
        else begin
          pa = pos_of[a];
          pb = pos_of[b];
          r1 = pa / SIDE;
          c1 = pa % SIDE;
          r2 = pb / SIDE;
          c2 = pb % SIDE;
          stepv = (cmd == CMD_ENC) ? 1 : SIDE - 1;
          if (r1 == r2) begin
            c1 = (c1 + stepv) % SIDE;
            c2 = (c2 + stepv) % SIDE;
          end else if (c1 == c2) begin
            r1 = (r1 + stepv) % SIDE;
            r2 = (r2 + stepv) % SIDE;
          end else begin
            t = c1;
            c1 = c2;
            c2 = t;
          end
          r.a = sq_cell[r1 * SIDE + c1];
          r.b = sq_cell[r2 * SIDE + c2];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(input logic [2:0] cmd, input letter_t a, input letter_t b);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_letter_a <= a;
    in_letter_b <= b;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_FILL && !sq_ready) n_squares++;
    if (cmd == CMD_ENC || cmd == CMD_DEC) n_pairs++;
    if (cmd <= CMD_DEC) n_words_in++;
    cipher_words_q.push_back(playfair_predict(cmd, a, b));
  endtask

  task automatic build_random_square(input bit full_key);
    letter_t perm [LETTERS];
    letter_t tmp;
    int j, n;
    send_word(CMD_CLEAR, letter_t'($urandom), letter_t'($urandom));
    if (full_key) begin
      for (int i = 0; i < LETTERS; i++) perm[i] = letter_t'(i);
      for (int i = LETTERS - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
      for (int i = 0; i < LETTERS; i++) send_word(CMD_KEY, perm[i], letter_t'($urandom));
      send_word(CMD_KEY, letter_t'($urandom_range(0, LETTERS - 1)), letter_t'($urandom));
    end else begin
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) send_word(CMD_KEY, letter_t'($urandom), letter_t'($urandom));
        else send_word(CMD_KEY, letter_t'($urandom_range(0, LETTERS - 1)), letter_t'($urandom));
      end
    end
  endtask

  task automatic send_random_pairs(input int n);
    int r, row, col;
    logic [2:0] op;
    letter_t a, b;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      op = $urandom_range(0, 1) ? CMD_ENC : CMD_DEC;
      if (r < 85 && !sq_ready) r = 90;
      if (r < 30) begin
        row = $urandom_range(0, SIDE - 1);
        a = sq_cell[row * SIDE + $urandom_range(0, SIDE - 1)];
        b = sq_cell[row * SIDE + $urandom_range(0, SIDE - 1)];
      end else if (r < 55) begin
        col = $urandom_range(0, SIDE - 1);
        a = sq_cell[$urandom_range(0, SIDE - 1) * SIDE + col];
        b = sq_cell[$urandom_range(0, SIDE - 1) * SIDE + col];
      end else if (r < 85) begin
        a = sq_cell[$urandom_range(0, CELLS - 1)];
        b = sq_cell[$urandom_range(0, CELLS - 1)];
      end else begin
        a = letter_t'($urandom);
        b = letter_t'($urandom);
        if (r >= 92 && r < 96) op = 3'($urandom_range(CMD_DEC + 1, CMD_LAST));
        else if (r >= 96) op = $urandom_range(0, 1) ? CMD_KEY : CMD_FILL;
      end
      send_word(op, a, b);
    end
  endtask

  task automatic test_early_commands;
    send_word(CMD_ENC, letter_t'(0), letter_t'(LETTERS - 1));
    send_word(CMD_DEC, letter_t'(LETTERS - 1), letter_t'(0));
    send_word(CMD_DEC + 3'd1, letter_t'(LETTERS - 1), letter_t'(LETTERS - 1));
    send_word(CMD_LAST, '1, '1);
    send_word(CMD_KEY, '1, '0);
  endtask

  task automatic test_square_build;
    send_word(CMD_CLEAR, '0, '0);
    send_word(CMD_KEY, letter_t'(LETTERS - 1), '0);
    send_word(CMD_KEY, LETTER_J, '0);
    send_word(CMD_KEY, LETTER_I, '0);
    send_word(CMD_KEY, letter_t'(0), '0);
    send_word(CMD_KEY, letter_t'(LETTERS - 1), '0);
    send_word(CMD_KEY, letter_t'(10), '0);
    send_word(CMD_KEY, letter_t'(4), '0);
    send_word(CMD_FILL, '0, '0);
    send_word(CMD_KEY, letter_t'(2), '0);
    send_word(CMD_FILL, '0, '0);
  endtask

  task automatic test_pair_rules;
    send_word(CMD_ENC, sq_cell[0], sq_cell[SIDE - 1]);
    send_word(CMD_ENC, sq_cell[0], sq_cell[CELLS - SIDE]);
    send_word(CMD_DEC, sq_cell[6], sq_cell[18]);
    send_word(CMD_ENC, sq_cell[12], sq_cell[12]);
    send_word(CMD_DEC, sq_cell[2], sq_cell[CELLS - 3]);
    send_word(CMD_ENC, LETTER_J, sq_cell[3]);
    send_word(CMD_DEC, '1, letter_t'(0));
  endtask

  task automatic test_output_backpressure;
    hold_order <= hold_order + 1;
    tx_quiet = 1'b1;
    build_random_square(1'b0);
    send_word(CMD_FILL, '0, '0);
    send_random_pairs(12);
    tx_quiet = 1'b0;
  endtask

  task automatic test_random_sessions;
    int start, s;
    bit first;
    start = n_words_in;
    first = 1'b1;
    while (n_words_in - start < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) == 0) tx_quiet = ~tx_quiet;
      s = first ? 0 : $urandom_range(0, 99);
      if (s < 80) begin
        build_random_square(first || $urandom_range(0, 7) == 0);
        send_word(CMD_FILL, letter_t'($urandom), letter_t'($urandom));
        send_random_pairs($urandom_range(8, 30));
      end else if (s < 90) begin
        build_random_square(1'b0);
        send_random_pairs($urandom_range(2, 6));
      end else begin
        send_word(CMD_KEY, letter_t'($urandom), letter_t'($urandom));
        send_word(CMD_FILL, letter_t'($urandom), letter_t'($urandom));
        send_random_pairs($urandom_range(2, 8));
      end
      first = 1'b0;
    end
    tx_quiet = 1'b0;
  endtask

  // result side: random ready, long hold-off on request, and the word check
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_word = '{out_a, out_b, out_status};
      n_words_out++;
      if (cipher_words_q.size() == 0) begin
        if (n_errors < 10) $display("unexpected word: a=%0d b=%0d status=%0d", out_a, out_b,
                                    out_status);
        n_errors++;
      end else begin
        want_word = cipher_words_q.pop_front();
        if (got_word !== want_word) begin
          if (n_errors < 10)
            $display({"mismatch on word %0d: expected a=%0d b=%0d status=%0d,",
                      " got a=%0d b=%0d status=%0d"},
                     n_words_out, want_word.a, want_word.b, want_word.st,
                     got_word.a, got_word.b, got_word.st);
          n_errors++;
        end
      end
    end
    if (++rx_run >= 128) begin
      rx_run = 0;
      rx_quiet = ($urandom_range(0, 3) == 0);
    end
    if (hold_order != hold_seen) begin
      hold_seen = hold_order;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      rx_gap = pick_gap(rx_quiet);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", idle_cycles);
      $display("[playfair_digraph_cipher] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_early_commands();
    test_square_build();
    test_pair_rules();
    test_output_backpressure();
    test_random_sessions();
    in_valid <= 1'b0;
    while (cipher_words_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d command words and %0d result words checked", n_words_in, n_words_out);
    $display("built %0d key squares, ran %0d pair lookups, %0d mismatches", n_squares, n_pairs,
             n_errors);
    if (n_errors == 0) $display("[playfair_digraph_cipher] OK");
    else $display("[playfair_digraph_cipher] ERROR");
    $finish;
  end

endmodule
